// ===== src/pat_pkg.sv =====
// Shared types and constants for the pool allocation tracker.
// Used by every module of the block except pat_ram; depends on nothing.
package pat_pkg;

  localparam int OFFSET_BITS = 16;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_BIG   = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_RETRIES   = 3'd6;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_POOL = 2'd1;
  localparam logic [1:0] CFG_SEED = 2'd2;

  localparam logic [15:0] POOL_RESET = 16'd4096;
  localparam logic [15:0] SEED_RESET = 16'd1;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  typedef struct packed {
    logic       capture;
    logic       set_err;
    logic [2:0] err;
    logic       lfsr_step;
    logic       div_start;
    logic       take_rem;
    logic       clr_idx;
    logic       inc_idx;
    logic       rd_idx;
    logic       rd_next;
    logic       rd_last;
    logic       seq_start;
    logic       zero_start;
    logic       place_commit;
    logic       hit_commit;
    logic       wr_shift;
    logic       free_commit;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_big;
    logic full;
    logic mode;
    logic count_zero;
    logic outside;
    logic div_done;
    logic idx_at_count;
    logic overlap;
    logic tries_max;
    logic no_space;
    logic match;
    logic shift_end;
  } stat_t;

endpackage

// ===== src/pat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pat_divider.sv =====
// Restoring divider producing the remainder, one bit per cycle.
// Depends on pat_pkg.
module pat_divider
  import pat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [OFFSET_BITS-1:0] dividend,
  input  logic [OFFSET_BITS-1:0] divisor,
  output logic [OFFSET_BITS-1:0] rem,
  output logic                   valid
);

  localparam int CNTW = $clog2(OFFSET_BITS + 1);

  logic [OFFSET_BITS-1:0] quo;
  logic [OFFSET_BITS-1:0] dvs;
  logic [CNTW-1:0]        cnt;
  logic                   run;
  logic [OFFSET_BITS:0]   trial;

  assign trial = {rem, quo[OFFSET_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (start) begin
      run   <= 1'b1;
      valid <= 1'b0;
      cnt   <= CNTW'(OFFSET_BITS);
      rem   <= '0;
      quo   <= dividend;
      dvs   <= divisor;
    end else if (run) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= OFFSET_BITS'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[OFFSET_BITS-1:0];
      end
      quo <= quo << 1;
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        run   <= 1'b0;
        valid <= 1'b1;
      end
    end
  end

endmodule

// ===== src/pat_datapath.sv =====
// Datapath: configuration, counters, LFSR, descriptor RAM and result registers.
// Depends on pat_pkg, pat_ram and pat_divider.
module pat_datapath
  import pat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int MAX_TRIES   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  output stat_t                          stat,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           op,
  input  logic [15:0]                    size,
  input  logic [15:0]                    offset,
  output logic [2:0]                     status,
  output logic [15:0]                    block_start,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] slot,
  output logic [15:0]                    bytes_placed,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] used_entries
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = $clog2(MAX_TRIES + 1);
  localparam int OB = OFFSET_BITS;

  logic          mode;
  logic [OB-1:0] pool_size;
  logic [OB-1:0] lfsr;
  logic [OB-1:0] lfsr_nxt;
  logic [CW-1:0] count;
  logic [OB-1:0] sum;
  logic          r_op;
  logic [OB-1:0] r_size;
  logic [OB-1:0] r_offset;
  logic [OB-1:0] cand;
  logic [CW-1:0] idx;
  logic [CW-1:0] hit;
  logic [TW-1:0] tries;
  logic [2:0]    res_status;
  logic [OB-1:0] res_bstart;
  logic [CW-1:0] res_slot;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [2*OB-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [2*OB-1:0] ram_rdata;
  logic [OB-1:0]   d_start;
  logic [OB-1:0]   d_size;
  logic [OB:0]     d_end;
  logic [OB:0]     c_end;
  logic [CW-1:0]   idx_p1;
  logic [CW-1:0]   count_m1;
  logic [OB-1:0]   div_rem;
  logic            div_valid;

  assign lfsr_nxt = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
  assign d_start  = ram_rdata[2*OB-1:OB];
  assign d_size   = ram_rdata[OB-1:0];
  assign d_end    = {1'b0, d_start} + {1'b0, d_size};
  assign c_end    = {1'b0, cand} + {1'b0, r_size};
  assign idx_p1   = idx + 1'b1;
  assign count_m1 = count - 1'b1;

  assign ram_we    = cmd.place_commit | cmd.wr_shift;
  assign ram_waddr = cmd.place_commit ? count[AW-1:0] : idx[AW-1:0];
  assign ram_wdata = cmd.place_commit ? {cand, r_size} : ram_rdata;
  assign ram_re    = cmd.rd_idx | cmd.rd_next | cmd.rd_last;
  assign ram_raddr = cmd.rd_last ? count_m1[AW-1:0] :
                     (cmd.rd_next ? idx_p1[AW-1:0] : idx[AW-1:0]);

  pat_ram #(.WIDTH(2 * OB), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pat_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (lfsr_nxt),
    .divisor  (pool_size - r_size),
    .rem      (div_rem),
    .valid    (div_valid)
  );

  always_comb begin
    stat.is_free      = r_op;
    stat.too_big      = r_size >= pool_size;
    stat.full         = count == CW'(TABLE_DEPTH);
    stat.mode         = mode;
    stat.count_zero   = count == '0;
    stat.outside      = r_offset > pool_size;
    stat.div_done     = div_valid;
    stat.idx_at_count = idx == count;
    stat.overlap      = ({1'b0, d_start} < c_end) && ({1'b0, cand} < d_end);
    stat.tries_max    = tries == TW'(MAX_TRIES);
    stat.no_space     = c_end >= {1'b0, pool_size};
    stat.match        = d_start == r_offset;
    stat.shift_end    = idx_p1 >= count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      pool_size <= POOL_RESET;
      lfsr      <= SEED_RESET;
      count     <= '0;
      sum       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: mode <= cfg_data[0];
          CFG_POOL: pool_size <= cfg_data;
          CFG_SEED: lfsr <= (cfg_data == '0) ? SEED_RESET : cfg_data;
          default: ;
        endcase
      end
      if (cmd.lfsr_step) begin
        lfsr <= lfsr_nxt;
      end
      if (cmd.place_commit) begin
        count <= count + 1'b1;
        sum   <= sum + r_size;
      end
      if (cmd.hit_commit) begin
        sum <= sum - d_size;
      end
      if (cmd.free_commit) begin
        count <= count_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_op       <= op;
      r_size     <= size;
      r_offset   <= offset;
      tries      <= '0;
      res_status <= ST_OK;
      res_bstart <= '0;
      res_slot   <= CW'(TABLE_DEPTH);
    end
    if (cmd.set_err) begin
      res_status <= cmd.err;
    end
    if (cmd.lfsr_step) begin
      tries <= tries + 1'b1;
    end
    if (cmd.take_rem) begin
      cand <= div_rem;
    end
    if (cmd.seq_start) begin
      cand <= d_end[OB-1:0];
    end
    if (cmd.zero_start) begin
      cand <= '0;
    end
    if (cmd.clr_idx) begin
      idx <= '0;
    end
    if (cmd.inc_idx) begin
      idx <= idx_p1;
    end
    if (cmd.place_commit) begin
      res_slot   <= count;
      res_bstart <= cand;
    end
    if (cmd.hit_commit) begin
      hit <= idx;
    end
    if (cmd.free_commit) begin
      res_slot   <= hit;
      res_bstart <= r_offset;
    end
    if (cmd.load_out) begin
      status       <= res_status;
      block_start  <= res_bstart;
      slot         <= res_slot;
      used_entries <= count;
      if (mode) begin
        bytes_placed <= sum;
      end else if (count == '0) begin
        bytes_placed <= '0;
      end else begin
        bytes_placed <= d_end[OB-1:0];
      end
    end
  end

endmodule

// ===== src/pat_ctrl.sv =====
// Controller state machine sequencing scans, retries, shifts and reporting.
// Depends on pat_pkg.
module pat_ctrl
  import pat_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SEQ_RD, S_SEQ_WAIT, S_RSTEP, S_RDIV, S_OSCAN, S_OCHK,
    S_PLACE, S_FSCAN, S_FCHK, S_SHRD, S_SHWR, S_REPORT, S_RWAIT, S_FINISH
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.is_free) begin
          if (stat.too_big) begin
            cmd.set_err = 1'b1;
            cmd.err     = ST_TOO_BIG;
            state_next  = S_REPORT;
          end else if (stat.full) begin
            cmd.set_err = 1'b1;
            cmd.err     = ST_FULL;
            state_next  = S_REPORT;
          end else if (stat.mode) begin
            state_next = S_RSTEP;
          end else if (stat.count_zero) begin
            cmd.zero_start = 1'b1;
            state_next     = S_PLACE;
          end else begin
            state_next = S_SEQ_RD;
          end
        end else if (stat.outside) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_OUTSIDE;
          state_next  = S_REPORT;
        end else begin
          cmd.clr_idx = 1'b1;
          state_next  = S_FSCAN;
        end
      end
      S_SEQ_RD: begin
        cmd.rd_last = 1'b1;
        state_next  = S_SEQ_WAIT;
      end
      S_SEQ_WAIT: begin
        cmd.seq_start = 1'b1;
        state_next    = S_PLACE;
      end
      S_RSTEP: begin
        cmd.lfsr_step = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = S_RDIV;
      end
      S_RDIV: begin
        if (stat.div_done) begin
          cmd.take_rem = 1'b1;
          cmd.clr_idx  = 1'b1;
          state_next   = S_OSCAN;
        end
      end
      S_OSCAN: begin
        if (stat.idx_at_count) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_OCHK;
        end
      end
      S_OCHK: begin
        if (!stat.overlap) begin
          cmd.inc_idx = 1'b1;
          state_next  = S_OSCAN;
        end else if (stat.tries_max) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_RETRIES;
          state_next  = S_REPORT;
        end else begin
          state_next = S_RSTEP;
        end
      end
      S_PLACE: begin
        if (stat.no_space) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_NO_SPACE;
        end else begin
          cmd.place_commit = 1'b1;
        end
        state_next = S_REPORT;
      end
      S_FSCAN: begin
        if (stat.idx_at_count) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_NOT_FOUND;
          state_next  = S_REPORT;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        if (stat.match) begin
          cmd.hit_commit = 1'b1;
          state_next     = S_SHRD;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_FSCAN;
        end
      end
      S_SHRD: begin
        if (stat.shift_end) begin
          cmd.free_commit = 1'b1;
          state_next      = S_REPORT;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        cmd.inc_idx  = 1'b1;
        state_next   = S_SHRD;
      end
      S_REPORT: begin
        if (stat.mode || stat.count_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_last = 1'b1;
          state_next  = S_RWAIT;
        end
      end
      S_RWAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.load_out = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_FINISH;
      if (state == S_IDLE && start) begin
        busy <= 1'b1;
      end else if (state == S_FINISH) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== src/pool_allocation_tracker_top.sv =====
// Top level of the pool allocation tracker.
// Depends on pat_pkg, pat_ctrl and pat_datapath.
//
// Usage:
//   Issue a transaction by raising start while busy is low; op, size and
//   offset are sampled at that edge. op 0 allocates size bytes, op 1 frees
//   the block that starts at offset.
//   The result (status, block_start, slot, bytes_placed, used_entries)
//   appears for exactly one cycle with done high, and busy falls in that
//   same cycle, so the next start may be accepted there. The receiver has
//   no way to stall; capture the result when done is high.
//   Errors found up front need no scan; a sequential allocate reads only
//   the last descriptor. A free scans up to the match, then shifts each
//   later descriptor down. A random allocate makes up to MAX_TRIES draws,
//   each running the remainder unit, then checking the descriptors. All
//   scans and shifts go through the single read port of the descriptor RAM.
//   Configuration is written through cfg_we, cfg_index and cfg_data while
//   the block is idle, a rule for the user that the block does not enforce:
//   0 mode, 1 pool size, 2 seed (also loads the LFSR).
//   Reset empties the table, clears the size sum and restores the register
//   defaults (sequential mode, pool 4096, seed 1).
module pool_allocation_tracker_top
  import pat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int MAX_TRIES   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             op,
  input  logic [15:0]                      size,
  input  logic [15:0]                      offset,
  output logic                             done,
  output logic [2:0]                       status,
  output logic [15:0]                      block_start,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] slot,
  output logic [15:0]                      bytes_placed,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] used_entries,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  pat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  pat_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_TRIES(MAX_TRIES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .size         (size),
    .offset       (offset),
    .status       (status),
    .block_start  (block_start),
    .slot         (slot),
    .bytes_placed (bytes_placed),
    .used_entries (used_entries)
  );

endmodule

// ===== src/pat_checker.sv =====
// Port-level checker for the pool allocation tracker, bound to the top level.
// Depends on pat_pkg and pool_allocation_tracker_top.
module pat_checker
  import pat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [2:0]                       status,
  input logic [15:0]                      block_start,
  input logic [$clog2(TABLE_DEPTH+1)-1:0] slot,
  input logic [$clog2(TABLE_DEPTH+1)-1:0] used_entries
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> block_start == '0 && slot == CW'(TABLE_DEPTH))
    else $error("error result carries a block");

  a_ok_slot: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK |-> slot < CW'(TABLE_DEPTH) &&
      used_entries <= CW'(TABLE_DEPTH))
    else $error("good result with bad slot or count");

endmodule

bind pool_allocation_tracker_top pat_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_pat_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .block_start  (block_start),
  .slot         (slot),
  .used_entries (used_entries)
);
